// File: src/checksummed_frame_receiver_defines.svh
// ---------------------------------------------------------------------------
// Checksummed frame receiver assertion macros
// Shared property forms for the receiver's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef CHECKSUMMED_FRAME_RECEIVER_DEFINES_SVH
`define CHECKSUMMED_FRAME_RECEIVER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CFR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cfr_pkg.sv
// ---------------------------------------------------------------------------
// cfr_pkg
// Types and constants shared by the checksummed frame receiver modules.
// ---------------------------------------------------------------------------
package cfr_pkg;

  localparam int MAX_DATA   = 32;
  localparam int HDR_BYTES  = 3;
  localparam int ADDR_W     = $clog2(MAX_DATA);
  localparam int FC_W       = 7;
  localparam int IDX_W      = 6;
  localparam int CFG_ADDR_W = 4;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 4;

  // Positions of the header bytes within a frame.
  localparam logic [FC_W-1:0] FC_CHK = FC_W'(0);
  localparam logic [FC_W-1:0] FC_CMD = FC_W'(1);
  localparam logic [FC_W-1:0] FC_LEN = FC_W'(2);

  // Field count once the header is in, and once the payload buffer is full.
  localparam logic [FC_W-1:0] FC_HDR  = FC_W'(HDR_BYTES);
  localparam logic [FC_W-1:0] FC_FULL = FC_W'(MAX_DATA + HDR_BYTES);

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_PREAMBLE  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_POSTAMBLE = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] CFG_ACK       = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] CFG_NACK      = CFG_ADDR_W'(3);

  localparam logic [7:0] PREAMBLE_RST  = 8'd254;
  localparam logic [7:0] POSTAMBLE_RST = 8'd253;
  localparam logic [7:0] ACK_RST       = 8'd250;
  localparam logic [7:0] NACK_RST      = 8'd251;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_ACK      = 3'd1,
    KIND_NACK     = 3'd2,
    KIND_CSUM_ERR = 3'd3,
    KIND_OVERSIZE = 3'd4
  } kind_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;     // input byte transfer this cycle
    logic rd_issue;   // read payload buffer at the run index
    logic load_data;  // load a data result into the output register
    logic idx_inc;    // advance the run index
  } cmd_t;

  // Datapath to controller, decoded from the byte on the input.
  typedef struct packed {
    logic run_start;  // byte ends a good data frame with payload
    logic single;     // byte gives one result
    logic idx_last;   // run index is on the final payload byte
  } sts_t;

endpackage

// File: src/cfr_ram.sv
// ---------------------------------------------------------------------------
// cfr_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/cfr_ctrl.sv
// ---------------------------------------------------------------------------
// cfr_ctrl
// Sequencer for byte intake, payload read-out and the output valid flag.
// ---------------------------------------------------------------------------
module cfr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  cfr_pkg::sts_t sts,
  output cfr_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_RD,
    ST_WR
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  // The output register can take a new result when empty or being drained.
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_RUN) && out_free;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.accept    = accept;
    case (state_r)
      ST_RUN: begin
        if (accept && sts.single) begin
          out_valid_nxt = 1'b1;
        end
        if (accept && sts.run_start) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_WR;
      end
      ST_WR: begin
        if (out_free) begin
          cmd.load_data = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.idx_last) begin
            state_nxt = ST_RUN;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// File: src/cfr_dpath.sv
// ---------------------------------------------------------------------------
// cfr_dpath
// Frame capture registers, checksum, payload buffer and output register.
// ---------------------------------------------------------------------------
module cfr_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [cfr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [7:0]                          cfg_wdata,
  input  logic [7:0]                          rx_byte,
  input  cfr_pkg::cmd_t                       cmd,
  output cfr_pkg::sts_t                       sts,
  output logic [cfr_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [cfr_pkg::OUT_USER_W-1:0]      out_tuser,
  output logic                                out_tlast
);

  logic [7:0] preamble_r, postamble_r, ack_r, nack_r;

  logic                       in_frame_r;
  logic [7:0]                 prev_r;
  logic [cfr_pkg::FC_W-1:0]   fc_r;
  logic [7:0]                 sum_r;
  logic [7:0]                 chk_r;
  logic [7:0]                 cmd_byte_r;
  logic [7:0]                 len_r;
  logic [cfr_pkg::IDX_W-1:0]  idx_r;

  cfr_pkg::kind_t             kind_r;
  logic                       has_r;
  logic [7:0]                 data_r;
  logic [cfr_pkg::IDX_W-1:0]  bidx_r;
  logic                       last_r;

  logic                       start;
  logic                       end_ok;
  logic                       capture;
  logic                       overflow;
  logic                       good;
  cfr_pkg::kind_t             end_kind;
  logic [cfr_pkg::FC_W-1:0]   data_pos;
  logic [7:0]                 ram_rdata;
  logic                       ram_we;

  assign data_pos = fc_r - cfr_pkg::FC_HDR;
  assign start    = !in_frame_r && (prev_r == preamble_r) && (rx_byte == preamble_r);
  // The frame ends only once the data count has caught up with the length byte.
  assign end_ok   = in_frame_r && (rx_byte == postamble_r) && (fc_r >= cfr_pkg::FC_HDR) &&
                    (len_r == {1'b0, data_pos});
  assign capture  = in_frame_r && !end_ok && (fc_r < cfr_pkg::FC_FULL);
  assign overflow = in_frame_r && !end_ok && (fc_r >= cfr_pkg::FC_FULL);
  assign good     = (sum_r == chk_r);

  always_comb begin
    if (!good) begin
      end_kind = cfr_pkg::KIND_CSUM_ERR;
    end else if (cmd_byte_r == ack_r) begin
      end_kind = cfr_pkg::KIND_ACK;
    end else if (cmd_byte_r == nack_r) begin
      end_kind = cfr_pkg::KIND_NACK;
    end else begin
      end_kind = cfr_pkg::KIND_DATA;
    end
  end

  assign sts.run_start = end_ok && (end_kind == cfr_pkg::KIND_DATA) && (len_r != 8'd0);
  assign sts.single    = (end_ok && !sts.run_start) || overflow;
  assign sts.idx_last  = (({2'b00, idx_r} + 8'd1) == len_r);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_r  <= cfr_pkg::PREAMBLE_RST;
      postamble_r <= cfr_pkg::POSTAMBLE_RST;
      ack_r       <= cfr_pkg::ACK_RST;
      nack_r      <= cfr_pkg::NACK_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        cfr_pkg::CFG_PREAMBLE:  preamble_r  <= cfg_wdata;
        cfr_pkg::CFG_POSTAMBLE: postamble_r <= cfg_wdata;
        cfr_pkg::CFG_ACK:       ack_r       <= cfg_wdata;
        cfr_pkg::CFG_NACK:      nack_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      prev_r     <= 8'd0;
      fc_r       <= '0;
      sum_r      <= 8'd0;
      chk_r      <= 8'd0;
      cmd_byte_r <= 8'd0;
      len_r      <= 8'd0;
    end else if (cmd.accept) begin
      if (!in_frame_r) begin
        prev_r <= rx_byte;
        if (start) begin
          in_frame_r <= 1'b1;
          fc_r       <= '0;
          sum_r      <= 8'd0;
        end
      end else if (end_ok) begin
        in_frame_r <= 1'b0;
        prev_r     <= rx_byte;
      end else if (capture) begin
        case (fc_r)
          cfr_pkg::FC_CHK: chk_r <= rx_byte;
          cfr_pkg::FC_CMD: begin
            cmd_byte_r <= rx_byte;
            sum_r      <= sum_r + rx_byte;
          end
          cfr_pkg::FC_LEN: begin
            len_r <= rx_byte;
            sum_r <= sum_r + rx_byte;
          end
          default: sum_r <= sum_r + rx_byte;
        endcase
        fc_r   <= fc_r + cfr_pkg::FC_W'(1);
        prev_r <= rx_byte;
      end else begin
        // Buffer overflow: drop the frame and start hunting afresh.
        in_frame_r <= 1'b0;
        fc_r       <= '0;
        sum_r      <= 8'd0;
        prev_r     <= 8'd0;
      end
    end
  end

  // Payload read-out index.
  always_ff @(posedge clk) begin
    if (cmd.accept && sts.run_start) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + cfr_pkg::IDX_W'(1);
    end
  end

  assign ram_we = cmd.accept && capture && (fc_r >= cfr_pkg::FC_HDR);

  cfr_ram #(
    .WIDTH (8),
    .DEPTH (cfr_pkg::MAX_DATA)
  ) u_payload (
    .clk   (clk),
    .we    (ram_we),
    .waddr (data_pos[cfr_pkg::ADDR_W-1:0]),
    .wdata (rx_byte),
    .re    (cmd.rd_issue),
    .raddr (idx_r[cfr_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.load_data) begin
      kind_r <= cfr_pkg::KIND_DATA;
      has_r  <= 1'b1;
      data_r <= ram_rdata;
      bidx_r <= idx_r;
      last_r <= sts.idx_last;
    end else if (cmd.accept && sts.single) begin
      kind_r <= overflow ? cfr_pkg::KIND_OVERSIZE : end_kind;
      has_r  <= 1'b0;
      data_r <= 8'd0;
      bidx_r <= '0;
      last_r <= 1'b1;
    end
  end

  // Command and length reflect the frame just ended; no input is taken while
  // a data run drains, so they hold for the whole run.
  assign out_tdata = {2'b00, bidx_r, data_r, len_r, cmd_byte_r};
  assign out_tuser = {has_r, kind_r};
  assign out_tlast = last_r;

endmodule

// File: src/checksummed_frame_receiver.sv
// ---------------------------------------------------------------------------
// checksummed_frame_receiver
// Serial byte deframer with preamble hunt, additive checksum and payload output.
// ---------------------------------------------------------------------------
// Each input transfer is one received byte, taken whenever the controller
// is not draining a data run and the output register is empty or being
// emptied. A frame is two preamble bytes, a checksum, a command, a length
// and up to 32 data bytes, closed by a postamble once the data count equals
// the length. An ack, nack, checksum error, oversize or empty data frame
// gives one result; a good data frame of length N > 0 gives N results, each
// read from the payload buffer through its one registered read port and each
// able to stall on the output; input is held off until the whole run is out.
`include "checksummed_frame_receiver_defines.svh"

module checksummed_frame_receiver (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [cfr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [7:0]                         cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] rx_byte
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] command, [15:8] frame_length, [23:16] data_byte, [29:24] byte_index
  output logic [cfr_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [cfr_pkg::OUT_USER_W-1:0]     out_tuser,  // [2:0] kind, [3] has_data
  output logic                               out_tlast
);

  cfr_pkg::cmd_t cmd;
  cfr_pkg::sts_t sts;

  cfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  cfr_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .rx_byte   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // A byte is only taken when a result it causes has somewhere to go.
  `CFR_ASSERT_SAME(a_ready_room, in_tready, (!out_tvalid || out_tready), "input ready with output full")
  // Payload read-out never overlaps byte intake.
  `CFR_ASSERT_SAME(a_drain_excl, cmd.load_data || cmd.rd_issue, !in_tready, "drain while taking input")
  // Once a data frame ends, intake stops until its run is out.
  `CFR_ASSERT_NEXT(a_run_stall, cmd.accept && sts.run_start, !in_tready, "input taken at run start")
  // The last data result sits on the final payload position.
  `CFR_ASSERT_SAME(a_last_index, out_tvalid && out_tuser[3] && out_tlast, (({2'b00, out_tdata[29:24]} + 8'd1) == out_tdata[15:8]), "last data index mismatch")

endmodule
